// ===== rtl/lte_pkg.sv =====
// ============================================================================
// lte_pkg: shared types and codes for the lease table
// Request and response payloads, command and status codes, default sizes.
// ============================================================================
`default_nettype none

package lte_pkg;

    // default sizes
    localparam int LTE_ENTRIES    = 16;
    localparam int LTE_OWNER_BITS = 32;

    // command codes
    localparam logic [1:0] CMD_ACQUIRE = 2'd0;
    localparam logic [1:0] CMD_RENEW   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_DENIED   = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] msg_id;
        logic [31:0] owner_id;
        logic [63:0] now_time;
        logic [63:0] lease_duration;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic       owned;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/lte_mem.sv =====
// ============================================================================
// lte_mem: lease table storage
// Single write port, single read port, registered read data.
// ============================================================================
`default_nettype none

module lte_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 161,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/lease_table_with_expiry.sv =====
// ============================================================================
// lease_table_with_expiry: lease table with expiry times
// Acquire, renew, release and ownership query over a fixed table of leases.
// ============================================================================
//
// Each request is one command (acquire, renew, release, query) on one message
// id for one owner at the given time, and yields exactly one response. The
// table lives in a single-port-read memory; every request scans all ENTRIES
// rows once, one row per cycle, then applies at most one write. The block
// accepts again only once the row-by-row scan through the memory read port
// and the apply step are done. After reset the block clears every row of
// the table and stalls requests meanwhile. A finished response sits in an
// output register, so the next request is taken while the response waits.
// ============================================================================
`default_nettype none

module lease_table_with_expiry #(
    parameter int ENTRIES    = lte_pkg::LTE_ENTRIES,
    parameter int OWNER_BITS = lte_pkg::LTE_OWNER_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // request channel
    input  wire logic          i_req_valid,
    output logic               o_req_stall,
    input  wire lte_pkg::t_req i_req,
    // response channel
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_stall,
    output lte_pkg::t_rsp      o_rsp
);

    import lte_pkg::*;

    // row index width and a counter wide enough to hold ENTRIES itself
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic                  valid;
        logic [63:0]           message;
        logic [OWNER_BITS-1:0] owner;
        logic [63:0]           expiry;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,   // post-reset clearing pass
        S_IDLE  = 4'b0010,   // waiting for a request
        S_SCAN  = 4'b0100,   // reading every row
        S_APPLY = 4'b1000    // write back and hand over response
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    logic          accept;
    logic          issue;
    logic          last;
    logic          emit;

    // read side
    logic [IW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    t_entry        rd_ent;
    logic          r_rd_vld;
    logic [IW-1:0] r_rd_idx;

    // write side
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    // latched request
    t_req                  r_req;
    logic [OWNER_BITS-1:0] r_own;
    logic [63:0]           r_new_exp;

    // scan results
    logic          r_hit;        // first valid row with this message
    logic [IW-1:0] r_hit_idx;
    logic          r_hit_live;   // that row has not expired
    logic          r_hit_mine;   // that row belongs to this owner
    logic          r_free;       // first invalid or expired row
    logic [IW-1:0] r_free_idx;
    logic          r_owned;

    // per-row checks
    logic          msg_eq;
    logic          row_live;
    logic          row_free;
    logic          owner_eq;

    // apply stage
    logic          ap_we;
    logic [IW-1:0] ap_idx;
    t_entry        ap_ent;
    t_rsp          ap_rsp;

    logic          r_rsp_valid;
    t_rsp          r_rsp;

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    assign accept = i_req_valid && (r_state == S_IDLE);
    assign issue  = (r_state == S_SCAN) && (r_cnt < CW'(ENTRIES));
    assign last   = r_rd_vld && (r_rd_idx == IW'(ENTRIES - 1));
    assign emit   = (r_state == S_APPLY) && (!r_rsp_valid || !i_rsp_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_cnt = r_cnt + CW'(1);
                end
                if (last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rd_vld <= issue;
            if (emit) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // table memory
    // ------------------------------------------------------------------
    assign rd_addr = issue ? r_cnt[IW-1:0] : '0;
    assign rd_ent  = rd_data;

    // clearing pass writes zero rows; otherwise the single apply write
    assign wr_en   = (r_state == S_CLEAR) || (emit && ap_we);
    assign wr_addr = (r_state == S_CLEAR) ? r_cnt[IW-1:0] : ap_idx;
    assign wr_data = (r_state == S_CLEAR) ? '0 : ap_ent;

    lte_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (EW),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // scan: one row per cycle, checked in the cycle after its read address
    // ------------------------------------------------------------------
    assign msg_eq   = rd_ent.valid && (rd_ent.message == r_req.msg_id);
    assign row_live = rd_ent.expiry > r_req.now_time;
    assign row_free = !rd_ent.valid || !row_live;
    assign owner_eq = rd_ent.owner == r_own;

    always_ff @(posedge i_clk) begin
        r_rd_idx <= rd_addr;

        if (accept) begin
            r_req   <= i_req;
            r_own   <= OWNER_BITS'(i_req.owner_id);
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_owned <= 1'b0;
        end

        // wrapping add, ready long before the apply cycle
        if (r_state == S_SCAN) begin
            r_new_exp <= r_req.now_time + r_req.lease_duration;
        end

        if (r_rd_vld) begin
            if (msg_eq && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_rd_idx;
                r_hit_live <= row_live;
                r_hit_mine <= owner_eq;
            end
            if (row_free && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            // owner zero never owns
            if (msg_eq && row_live && owner_eq && (r_own != '0)) begin
                r_owned <= 1'b1;
            end
        end

        if (emit) begin
            r_rsp <= ap_rsp;
        end
    end

    // ------------------------------------------------------------------
    // apply: decide status and the write-back from the scan results
    // ------------------------------------------------------------------
    always_comb begin
        ap_we          = 1'b0;
        ap_idx         = r_hit_idx;
        ap_ent.valid   = 1'b1;
        ap_ent.message = r_req.msg_id;
        ap_ent.owner   = r_own;
        ap_ent.expiry  = r_new_exp;
        ap_rsp.status  = ST_OK;
        ap_rsp.owned   = 1'b0;

        unique case (r_req.cmd)
            CMD_ACQUIRE: begin
                if ((r_req.msg_id == '0) || (r_own == '0) ||
                    (r_req.lease_duration == '0)) begin
                    ap_rsp.status = ST_INVALID;
                end else if (r_hit && r_hit_live && !r_hit_mine) begin
                    ap_rsp.status = ST_BUSY;
                end else if (r_hit) begin
                    ap_we = 1'b1;
                end else if (r_free) begin
                    ap_we  = 1'b1;
                    ap_idx = r_free_idx;
                end else begin
                    ap_rsp.status = ST_FULL;
                end
            end
            CMD_RENEW: begin
                if (r_own == '0) begin
                    ap_rsp.status = ST_INVALID;
                end else if (!r_hit) begin
                    ap_rsp.status = ST_NOTFOUND;
                end else if (!r_hit_mine || !r_hit_live) begin
                    ap_rsp.status = ST_DENIED;
                end else begin
                    ap_we = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (r_own == '0) begin
                    ap_rsp.status = ST_INVALID;
                end else if (!r_hit) begin
                    ap_rsp.status = ST_NOTFOUND;
                end else if (!r_hit_mine) begin
                    ap_rsp.status = ST_DENIED;
                end else begin
                    // release wipes the whole row
                    ap_we  = 1'b1;
                    ap_ent = '0;
                end
            end
            CMD_QUERY: begin
                ap_rsp.owned = r_owned;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ===== tb/lease_table_with_expiry_tb.sv =====
// ============================================================================
// lease_table_with_expiry_tb: self-checking bench for the lease table
// Drives acquire, renew, release and query requests through the valid/stall
// request channel and checks every response against a hand-typed answer or
// a cycle-free model of the table. A short scripted opening covers argument
// errors, not-found, busy, denied, expiry boundaries and 64-bit wrap; then
// phases of random lease traffic over small id pools run with sender bursts,
// receiver stalls, one long response hold-off and drain pauses.
// ============================================================================
module lease_table_with_expiry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lte_pkg::*;

    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam int MSG_POOL   = 24;    // more ids than slots, so the table can fill
    localparam int OWNER_POOL = 5;
    localparam int PHASES     = 8;
    localparam int TOTAL_REQS = 950;
    localparam int HOLD_CYCLES = 300;  // long response hold-off
    localparam int TAIL_CYCLES = 2 * (LTE_ENTRIES + 3);

    // one scripted request; lit is a hand-typed expected response
    typedef struct {
        t_req req;
        bit   has_lit;
        t_rsp lit;
    } t_script_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    t_req i_req       = '0;
    logic i_rsp_stall = 1'b0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // travels alongside i_req: use lit_rsp instead of the model's answer
    bit   lit_pending = 1'b0;
    t_rsp lit_rsp     = '0;

    // bench copy of the lease table, cleared like the block's at reset
    logic        tbl_valid  [LTE_ENTRIES] = '{default: '0};
    logic [63:0] tbl_msg    [LTE_ENTRIES] = '{default: '0};
    logic [31:0] tbl_owner  [LTE_ENTRIES] = '{default: '0};
    logic [63:0] tbl_expiry [LTE_ENTRIES] = '{default: '0};

    t_rsp        lease_rsp_due_q[$];   // responses still owed, oldest first
    int unsigned fail_count = 0;

    // random traffic shaping
    logic [63:0] msg_pool   [MSG_POOL];
    logic [31:0] owner_pool [OWNER_POOL];
    logic [63:0] now_cursor = '0;
    int unsigned dur_limit  = 100;

    // receiver hold-off handshake between the sender and the stall process
    int unsigned hold_asked = 0;
    int unsigned hold_done  = 0;

    lease_table_with_expiry DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Table model. Applies one request to the bench table and returns the
    // response the block owes for it.
    // ------------------------------------------------------------------------
    function automatic t_rsp predict_lease(input t_req r);
        t_rsp rsp;
        int   hit;
        int   slot;
        rsp = '{status: ST_OK, owned: 1'b0};

        // lowest valid entry holding this message; LTE_ENTRIES means none
        hit = LTE_ENTRIES;
        for (int i = LTE_ENTRIES - 1; i >= 0; i--) begin
            if (tbl_valid[i] && tbl_msg[i] == r.msg_id) begin
                hit = i;
            end
        end

        case (r.cmd)
            CMD_ACQUIRE: begin
                if (r.msg_id == '0 || r.owner_id == '0 || r.lease_duration == '0) begin
                    rsp.status = ST_INVALID;
                end else if (hit < LTE_ENTRIES && tbl_expiry[hit] > r.now_time &&
                             tbl_owner[hit] != r.owner_id) begin
                    rsp.status = ST_BUSY;
                end else begin
                    slot = hit;
                    // no match: first free or lapsed slot
                    if (slot == LTE_ENTRIES) begin
                        for (int i = LTE_ENTRIES - 1; i >= 0; i--) begin
                            if (!tbl_valid[i] || tbl_expiry[i] <= r.now_time) begin
                                slot = i;
                            end
                        end
                    end
                    if (slot == LTE_ENTRIES) begin
                        rsp.status = ST_FULL;
                    end else begin
                        tbl_valid[slot]  = 1'b1;
                        tbl_msg[slot]    = r.msg_id;
                        tbl_owner[slot]  = r.owner_id;
                        tbl_expiry[slot] = r.now_time + r.lease_duration;  // wraps
                    end
                end
            end
            CMD_RENEW: begin
                if (r.owner_id == '0) begin
                    rsp.status = ST_INVALID;
                end else if (hit == LTE_ENTRIES) begin
                    rsp.status = ST_NOTFOUND;
                end else if (tbl_owner[hit] != r.owner_id || tbl_expiry[hit] <= r.now_time) begin
                    rsp.status = ST_DENIED;
                end else begin
                    tbl_expiry[hit] = r.now_time + r.lease_duration;
                end
            end
            CMD_RELEASE: begin
                if (r.owner_id == '0) begin
                    rsp.status = ST_INVALID;
                end else if (hit == LTE_ENTRIES) begin
                    rsp.status = ST_NOTFOUND;
                end else if (tbl_owner[hit] != r.owner_id) begin
                    rsp.status = ST_DENIED;   // expiry is not looked at
                end else begin
                    tbl_valid[hit]  = 1'b0;
                    tbl_msg[hit]    = '0;
                    tbl_owner[hit]  = '0;
                    tbl_expiry[hit] = '0;
                end
            end
            default: begin
                // query: any live entry for this message and owner
                if (r.owner_id != '0) begin
                    for (int i = 0; i < LTE_ENTRIES; i++) begin
                        if (tbl_valid[i] && tbl_msg[i] == r.msg_id &&
                            tbl_expiry[i] > r.now_time && tbl_owner[i] == r.owner_id) begin
                            rsp.owned = 1'b1;
                        end
                    end
                end
            end
        endcase
        return rsp;
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checker. Everything is sampled at the rising edge, so values seen here
    // are the ones the block saw. Responses are checked before the request
    // of the same edge is queued, so a stray response cannot match it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : lease_checker
        t_rsp due;
        t_rsp model_rsp;
        if (i_rst_n) begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (lease_rsp_due_q.size() == 0) begin
                    report_failure($sformatf("response with none pending: status %0d owned %0d",
                                             o_rsp.status, o_rsp.owned));
                end else begin
                    due = lease_rsp_due_q.pop_front();
                    if (o_rsp.status !== due.status || o_rsp.owned !== due.owned) begin
                        report_failure($sformatf(
                            "response mismatch: status exp %0d got %0d, owned exp %0d got %0d",
                            due.status, o_rsp.status, due.owned, o_rsp.owned));
                    end
                end
            end
            if (i_req_valid && !o_req_stall) begin
                // model runs for every request so its table stays in step
                model_rsp = predict_lease(i_req);
                lease_rsp_due_q.push_back(lit_pending ? lit_rsp : model_rsp);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response stall. Random modes of random length, including stretches with
    // no stall at all; a hold-off asked for by the sender keeps stall high over
    // a long stretch so the block backs up and stalls its request side.
    // ------------------------------------------------------------------------
    initial begin : rsp_stall_gen
        int unsigned mode;
        int unsigned mode_left;
        int unsigned tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_done != hold_asked) begin
                hold_done++;
                i_rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 120);
                end
                mode_left--;
                case (mode)
                    0:       i_rsp_stall <= 1'b0;
                    1:       i_rsp_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_rsp_stall <= ($urandom_range(0, 3) != 0);
                    default: i_rsp_stall <= (tick % 7 < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------

    // offer one request and return at the edge where it was taken
    task automatic send_request(input t_req r, input bit has_lit, input t_rsp lit);
        i_req       <= r;
        i_req_valid <= 1'b1;
        lit_pending <= has_lit;
        lit_rsp     <= lit;
        do @(posedge i_clk); while (o_req_stall);
    endtask

    // stop offering and wait until every owed response is back; the first
    // edge lets the checker queue a request taken at the current edge
    task automatic wait_for_drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (lease_rsp_due_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_script_row mk_row(input logic [1:0] c, input logic [63:0] m,
                                           input logic [31:0] o, input logic [63:0] n,
                                           input logic [63:0] d, input bit has_lit,
                                           input logic [2:0] st, input logic ow);
        t_script_row row;
        row.req     = '{cmd: c, msg_id: m, owner_id: o, now_time: n, lease_duration: d};
        row.has_lit = has_lit;
        row.lit     = '{status: st, owned: ow};
        return row;
    endfunction

    // Mostly well-formed traffic over small id and owner pools with time
    // moving forward, so leases collide, lapse and fill the table; the rest
    // is fully random noise touching every bit of every field.
    function automatic t_req next_lease_cmd();
        t_req        r;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            r.cmd            = 2'($urandom);
            r.msg_id         = {$urandom, $urandom};
            r.owner_id       = $urandom;
            r.now_time       = {$urandom, $urandom};
            r.lease_duration = {$urandom, $urandom};
        end else begin
            pick  = $urandom_range(0, 99);
            r.cmd = (pick < 40) ? CMD_ACQUIRE :
                    (pick < 60) ? CMD_RENEW   :
                    (pick < 75) ? CMD_RELEASE : CMD_QUERY;
            r.msg_id     = msg_pool[$urandom_range(0, MSG_POOL - 1)];
            r.owner_id   = ($urandom_range(0, 99) < 3) ? '0 :
                           owner_pool[$urandom_range(0, OWNER_POOL - 1)];
            now_cursor   = now_cursor + 64'($urandom_range(0, 12));
            r.now_time   = now_cursor;
            pick = $urandom_range(0, 99);
            r.lease_duration = (pick < 4) ? '0 :
                               (pick < 7) ? {$urandom, $urandom} :
                               64'($urandom_range(1, dur_limit));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : lease_traffic
        t_script_row lease_script[$];
        int unsigned phase_dur [PHASES];
        int unsigned phase_gap [PHASES];
        int unsigned gap_max;
        int unsigned burst_left;
        int unsigned gap;
        int          per_phase;

        phase_dur = '{50, 2000, 400, 5000, 20, 1000, 3000, 200};
        phase_gap = '{0, 4, 8, 0, 2, 12, 0, 6};

        for (int i = 0; i < MSG_POOL; i++) begin
            msg_pool[i] = (i < 8) ? 64'(i + 1) : {$urandom, $urandom};
        end
        msg_pool[MSG_POOL - 1] = MAX64;
        owner_pool[0] = 32'd1;
        owner_pool[1] = MAX32;
        for (int i = 2; i < OWNER_POOL; i++) begin
            owner_pool[i] = $urandom | 32'd1;
        end

        // opening script: errors, boundaries and wrap on an empty table
        lease_script.push_back(mk_row(CMD_QUERY,   64'd5, 32'd7, 64'd0, 64'd0, 1, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_ACQUIRE, 64'd0, 32'd1, 64'd0, 64'd10,
                                      1, ST_INVALID, 1'b0));
        lease_script.push_back(mk_row(CMD_ACQUIRE, 64'd1, 32'd0, 64'd0, 64'd10,
                                      1, ST_INVALID, 1'b0));
        lease_script.push_back(mk_row(CMD_ACQUIRE, 64'd1, 32'd1, 64'd0, 64'd0,
                                      1, ST_INVALID, 1'b0));
        lease_script.push_back(mk_row(CMD_RENEW,   64'd1, 32'd0, 64'd0, 64'd10,
                                      1, ST_INVALID, 1'b0));
        lease_script.push_back(mk_row(CMD_RELEASE, 64'd1, 32'd0, 64'd0, 64'd0,
                                      1, ST_INVALID, 1'b0));
        lease_script.push_back(mk_row(CMD_RENEW,   64'd1, 32'd1, 64'd0, 64'd10,
                                      1, ST_NOTFOUND, 1'b0));
        lease_script.push_back(mk_row(CMD_RELEASE, 64'd1, 32'd1, 64'd0, 64'd0,
                                      1, ST_NOTFOUND, 1'b0));
        // all-ones message and owner, lease lapses at 150
        lease_script.push_back(mk_row(CMD_ACQUIRE, MAX64, MAX32, 64'd100, 64'd50,
                                      1, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_ACQUIRE, MAX64, 32'd1, 64'd120, 64'd5,
                                      1, ST_BUSY, 1'b0));
        lease_script.push_back(mk_row(CMD_QUERY,   MAX64, MAX32, 64'd149, 64'd0, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_QUERY,   MAX64, MAX32, 64'd150, 64'd0, 0, ST_OK, 1'b0));
        // lapsed lease is taken over by another owner in the same slot
        lease_script.push_back(mk_row(CMD_ACQUIRE, MAX64, 32'd1, 64'd150, 64'd5, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_RENEW,   MAX64, MAX32, 64'd151, 64'd10,
                                      1, ST_DENIED, 1'b0));
        // renew with zero length leaves a lease that has already lapsed
        lease_script.push_back(mk_row(CMD_RENEW,   MAX64, 32'd1, 64'd151, 64'd0, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_RENEW,   MAX64, 32'd1, 64'd151, 64'd10, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_RELEASE, MAX64, MAX32, 64'd151, 64'd0,
                                      1, ST_DENIED, 1'b0));
        // release of a lapsed lease still succeeds for its owner
        lease_script.push_back(mk_row(CMD_RELEASE, MAX64, 32'd1, 64'd200, 64'd0, 0, ST_OK, 1'b0));
        // expiry wraps past 2^64
        lease_script.push_back(mk_row(CMD_ACQUIRE, 64'd2, 32'd3, MAX64, MAX64, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_QUERY,   64'd2, 32'd3, 64'd0, 64'd0, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_QUERY,   64'd2, 32'd3, MAX64, 64'd0, 0, ST_OK, 1'b0));
        // message id zero never matches, owner zero never owns
        lease_script.push_back(mk_row(CMD_QUERY,   64'd0, 32'd3, 64'd0, 64'd0, 0, ST_OK, 1'b0));
        lease_script.push_back(mk_row(CMD_RENEW,   64'd0, 32'd3, 64'd0, 64'd10,
                                      1, ST_NOTFOUND, 1'b0));
        lease_script.push_back(mk_row(CMD_QUERY,   64'd2, 32'd0, 64'd0, 64'd0, 0, ST_OK, 1'b0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its table first; the stall handshake covers that
        foreach (lease_script[k]) begin
            send_request(lease_script[k].req, lease_script[k].has_lit, lease_script[k].lit);
        end

        per_phase  = (TOTAL_REQS - lease_script.size()) / PHASES;
        burst_left = 0;
        for (int p = 0; p < PHASES; p++) begin
            dur_limit  = phase_dur[p];
            gap_max    = phase_gap[p];
            // one phase runs up to the 64-bit time wrap
            now_cursor = (p == 4) ? MAX64 - 64'd3000 : {$urandom, $urandom};
            // back-to-back offers while the receiver holds off
            if (p == 3) begin
                hold_asked++;
            end
            for (int k = 0; k < per_phase; k++) begin
                if (burst_left == 0) begin
                    gap = $urandom_range(0, gap_max);
                    if (gap != 0) begin
                        i_req_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                    burst_left = $urandom_range(1, 16);
                end
                send_request(next_lease_cmd(), 1'b0, '0);
                burst_left--;
            end
            // pause until every response is home
            if (p == 1 || p == 5) begin
                wait_for_drain();
                burst_left = 0;
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lte_pkg.sv
rtl/lte_mem.sv
rtl/lease_table_with_expiry.sv
tb/lease_table_with_expiry_tb.sv
